>>> design/cam_pkg.sv
package cam_pkg;

  localparam int unsigned DATA_W    = 16;
  localparam int unsigned MASK_W    = 6;
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned CFG_IDX_W = 3;

  // default pair window length in ticks
  localparam int unsigned PAIR_WINDOW_TICKS_DEF = 4;

  // register reset values
  localparam logic signed [DATA_W-1:0] TEMP_HIGH_RST   = 16'sd3800;
  localparam logic signed [DATA_W-1:0] TEMP_LOW_RST    = 16'sd3740;
  localparam logic signed [DATA_W-1:0] HUMI_HIGH_RST   = 16'sd6000;
  localparam logic signed [DATA_W-1:0] HUMI_LOW_RST    = 16'sd5000;
  localparam logic signed [DATA_W-1:0] OFFSET_RST      = 16'sd0;
  localparam logic        [MASK_W-1:0] ENABLE_MASK_RST = 6'd0;
  localparam logic        [DATA_W-1:0] TIMEOUT_RST     = 16'd10;

  // enable mask bit positions
  localparam int unsigned EN_MONITOR   = 0;
  localparam int unsigned EN_TEMP_HIGH = 1;
  localparam int unsigned EN_TEMP_LOW  = 2;
  localparam int unsigned EN_HUMI_HIGH = 3;
  localparam int unsigned EN_HUMI_LOW  = 4;
  localparam int unsigned EN_MISSING   = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_HIGH   = 3'd0,
    REG_TEMP_LOW    = 3'd1,
    REG_HUMI_HIGH   = 3'd2,
    REG_HUMI_LOW    = 3'd3,
    REG_TEMP_OFFSET = 3'd4,
    REG_HUMI_OFFSET = 3'd5,
    REG_ENABLE_MASK = 3'd6,
    REG_TIMEOUT     = 3'd7
  } reg_index_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TEMP   = 2'd0,
    ACT_HUMI   = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_UNUSED = 2'd3
  } action_t;

  // channel status handed to the alarm evaluator
  typedef struct packed {
    logic temp_present;
    logic humi_present;
    logic temp_ever_seen;
    logic humi_ever_seen;
  } chan_status_t;

  // limit settings handed to the alarm evaluator
  typedef struct packed {
    logic signed [DATA_W-1:0] temp_high;
    logic signed [DATA_W-1:0] temp_low;
    logic signed [DATA_W-1:0] humi_high;
    logic signed [DATA_W-1:0] humi_low;
    logic        [MASK_W-1:0] enable_mask;
  } limits_t;

endpackage

>>> design/cam_if.sv
interface cam_in_if import cam_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ACTION_W-1:0]      action;
  logic signed [DATA_W-1:0] sample_value;

  modport source (output valid, action, sample_value, input ready);
  modport sink   (input valid, action, sample_value, output ready);
endinterface

interface cam_out_if;
  logic valid;
  logic ready;
  logic alarm;
  logic alarm_raised;
  logic alarm_cleared;
  logic temp_lost;
  logic humi_lost;
  logic pair_ready;

  modport source (output valid, alarm, alarm_raised, alarm_cleared, temp_lost, humi_lost,
                  pair_ready, input ready);
  modport sink   (input valid, alarm, alarm_raised, alarm_cleared, temp_lost, humi_lost,
                  pair_ready, output ready);
endinterface

>>> design/climate_alarm_monitor.sv
// climate alarm monitor: one temperature and one humidity channel
// result word: the result word for an item is registered as the item is accepted and shown from the next cycle
// throughput: one item per cycle while out_ch.ready is high; the single output register refills as it drains
// all state updates and the alarm evaluation fit between input port and result register
// reset (rst, synchronous, high): registers to defaults, state cleared, countdowns stopped
module climate_alarm_monitor import cam_pkg::*; #(
  parameter int unsigned PAIR_WINDOW_TICKS = PAIR_WINDOW_TICKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  cam_in_if.sink               in_ch,
  cam_out_if.source            out_ch
);

  localparam int unsigned PCD_W = $clog2(PAIR_WINDOW_TICKS + 1);
  localparam logic [PCD_W-1:0] PAIR_LOAD = PCD_W'(PAIR_WINDOW_TICKS);

  // configuration registers
  limits_t                  limits;
  logic signed [DATA_W-1:0] temp_offset;
  logic signed [DATA_W-1:0] humi_offset;
  logic        [DATA_W-1:0] no_data_timeout;

  // monitor state
  logic signed [DATA_W-1:0] temp_reading, temp_reading_next;
  logic signed [DATA_W-1:0] humi_reading, humi_reading_next;
  chan_status_t             status, status_next;
  logic                     temp_fresh, temp_fresh_next;
  logic                     humi_fresh, humi_fresh_next;
  logic        [DATA_W-1:0] temp_cd, temp_cd_next;
  logic        [DATA_W-1:0] humi_cd, humi_cd_next;
  logic        [PCD_W-1:0]  pair_cd, pair_cd_next;
  logic                     alarm_level, alarm_next;
  logic        [MASK_W-1:0] last_mask;

  // result register
  logic out_valid;
  logic res_alarm, res_raised, res_cleared, res_temp_lost, res_humi_lost, res_pair;

  logic                     accept;
  logic                     mask_chg, mon_rise, mon_fall;
  logic        [DATA_W-1:0] timeout_load;
  logic signed [DATA_W:0]   temp_sum, humi_sum;
  logic signed [DATA_W-1:0] temp_sat, humi_sat;
  logic                     eval, t_lost, h_lost, pair;
  logic                     eval_alarm;
  logic signed [DATA_W-1:0] sat_max, sat_min;

  assign sat_max = {1'b0, {(DATA_W-1){1'b1}}};
  assign sat_min = {1'b1, {(DATA_W-1){1'b0}}};

  // output register parts the two sides
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign mask_chg     = limits.enable_mask != last_mask;
  assign mon_rise     = mask_chg && !last_mask[EN_MONITOR] && limits.enable_mask[EN_MONITOR];
  assign mon_fall     = mask_chg && last_mask[EN_MONITOR] && !limits.enable_mask[EN_MONITOR];
  assign timeout_load = (no_data_timeout == '0) ? DATA_W'(1) : no_data_timeout;

  // calibration with saturation
  assign temp_sum = $signed({in_ch.sample_value[DATA_W-1], in_ch.sample_value}) +
                    $signed({temp_offset[DATA_W-1], temp_offset});
  assign humi_sum = $signed({in_ch.sample_value[DATA_W-1], in_ch.sample_value}) +
                    $signed({humi_offset[DATA_W-1], humi_offset});
  always_comb begin
    if (temp_sum[DATA_W] != temp_sum[DATA_W-1]) begin
      temp_sat = temp_sum[DATA_W] ? sat_min : sat_max;
    end else begin
      temp_sat = temp_sum[DATA_W-1:0];
    end
    if (humi_sum[DATA_W] != humi_sum[DATA_W-1]) begin
      humi_sat = humi_sum[DATA_W] ? sat_min : sat_max;
    end else begin
      humi_sat = humi_sum[DATA_W-1:0];
    end
  end

  // next state for one accepted item
  always_comb begin
    temp_reading_next = temp_reading;
    humi_reading_next = humi_reading;
    status_next       = status;
    temp_fresh_next   = temp_fresh;
    humi_fresh_next   = humi_fresh;
    temp_cd_next      = temp_cd;
    humi_cd_next      = humi_cd;
    pair_cd_next      = pair_cd;
    eval              = mask_chg;
    t_lost            = 1'b0;
    h_lost            = 1'b0;
    pair              = 1'b0;

    // mask change is handled ahead of the action
    if (mon_rise) begin
      status_next.temp_present = 1'b1;
      status_next.humi_present = 1'b1;
      temp_cd_next             = timeout_load;
      humi_cd_next             = timeout_load;
    end else if (mon_fall) begin
      temp_cd_next = '0;
      humi_cd_next = '0;
    end

    case (action_t'(in_ch.action))
      ACT_TEMP, ACT_HUMI: begin
        if (in_ch.action == ACT_TEMP) begin
          temp_reading_next          = temp_sat;
          status_next.temp_ever_seen = 1'b1;
          status_next.temp_present   = 1'b1;
          temp_fresh_next            = 1'b1;
          temp_cd_next               = timeout_load;
        end else begin
          humi_reading_next          = humi_sat;
          status_next.humi_ever_seen = 1'b1;
          status_next.humi_present   = 1'b1;
          humi_fresh_next            = 1'b1;
          humi_cd_next               = timeout_load;
        end
        if (temp_fresh_next && humi_fresh_next) begin
          pair            = 1'b1;
          eval            = 1'b1;
          temp_fresh_next = 1'b0;
          humi_fresh_next = 1'b0;
          pair_cd_next    = '0;
        end else if (pair_cd == '0) begin
          pair_cd_next = PAIR_LOAD;
        end
      end
      ACT_TICK: begin
        if (temp_cd_next != '0) begin
          if (temp_cd_next == DATA_W'(1)) begin
            status_next.temp_present = 1'b0;
            t_lost                   = 1'b1;
            eval                     = 1'b1;
          end
          temp_cd_next = temp_cd_next - DATA_W'(1);
        end
        if (humi_cd_next != '0) begin
          if (humi_cd_next == DATA_W'(1)) begin
            status_next.humi_present = 1'b0;
            h_lost                   = 1'b1;
            eval                     = 1'b1;
          end
          humi_cd_next = humi_cd_next - DATA_W'(1);
        end
        if (pair_cd != '0) begin
          if (pair_cd == PCD_W'(1)) begin
            pair            = 1'b1;
            eval            = 1'b1;
            temp_fresh_next = 1'b0;
            humi_fresh_next = 1'b0;
          end
          pair_cd_next = pair_cd - PCD_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  cam_eval u_eval (
    .limits       (limits),
    .status       (status_next),
    .temp_reading (temp_reading_next),
    .humi_reading (humi_reading_next),
    .alarm        (eval_alarm)
  );

  assign alarm_next = eval ? eval_alarm : alarm_level;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.temp_high   <= TEMP_HIGH_RST;
      limits.temp_low    <= TEMP_LOW_RST;
      limits.humi_high   <= HUMI_HIGH_RST;
      limits.humi_low    <= HUMI_LOW_RST;
      limits.enable_mask <= ENABLE_MASK_RST;
      temp_offset        <= OFFSET_RST;
      humi_offset        <= OFFSET_RST;
      no_data_timeout    <= TIMEOUT_RST;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_TEMP_HIGH:   limits.temp_high   <= cfg_data;
        REG_TEMP_LOW:    limits.temp_low    <= cfg_data;
        REG_HUMI_HIGH:   limits.humi_high   <= cfg_data;
        REG_HUMI_LOW:    limits.humi_low    <= cfg_data;
        REG_TEMP_OFFSET: temp_offset        <= cfg_data;
        REG_HUMI_OFFSET: humi_offset        <= cfg_data;
        REG_ENABLE_MASK: limits.enable_mask <= cfg_data[MASK_W-1:0];
        REG_TIMEOUT:     no_data_timeout    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // monitor state
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_reading <= '0;
      humi_reading <= '0;
      status       <= '0;
      temp_fresh   <= 1'b0;
      humi_fresh   <= 1'b0;
      temp_cd      <= '0;
      humi_cd      <= '0;
      pair_cd      <= '0;
      alarm_level  <= 1'b0;
      last_mask    <= '0;
    end else if (accept) begin
      temp_reading <= temp_reading_next;
      humi_reading <= humi_reading_next;
      status       <= status_next;
      temp_fresh   <= temp_fresh_next;
      humi_fresh   <= humi_fresh_next;
      temp_cd      <= temp_cd_next;
      humi_cd      <= humi_cd_next;
      pair_cd      <= pair_cd_next;
      alarm_level  <= alarm_next;
      last_mask    <= limits.enable_mask;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_alarm     <= alarm_next;
      res_raised    <= !alarm_level && alarm_next;
      res_cleared   <= alarm_level && !alarm_next;
      res_temp_lost <= t_lost;
      res_humi_lost <= h_lost;
      res_pair      <= pair;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.alarm         = res_alarm;
  assign out_ch.alarm_raised  = res_raised;
  assign out_ch.alarm_cleared = res_cleared;
  assign out_ch.temp_lost     = res_temp_lost;
  assign out_ch.humi_lost     = res_humi_lost;
  assign out_ch.pair_ready    = res_pair;

`ifndef SYNTHESIS
  // the pending word always reflects the current alarm level
  a_level_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (res_alarm == alarm_level))
    else $error("result word alarm differs from alarm level");

  // alarm only ever evaluated on while monitoring was enabled
  a_alarm_needs_monitor: assert property (@(posedge clk) disable iff (rst)
    alarm_level |-> last_mask[EN_MONITOR])
    else $error("alarm set while monitor disabled");

  // a lost channel is marked absent with its countdown stopped
  a_temp_lost_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_temp_lost) |-> (!status.temp_present && (temp_cd == '0)))
    else $error("temperature lost but channel still running");

  // pair window never loaded beyond its length
  a_pair_window: assert property (@(posedge clk) disable iff (rst)
    pair_cd <= PAIR_LOAD)
    else $error("pair countdown beyond window");
`endif

endmodule

>>> design/cam_eval.sv
module cam_eval import cam_pkg::*; (
  input  limits_t                  limits,
  input  chan_status_t             status,
  input  logic signed [DATA_W-1:0] temp_reading,
  input  logic signed [DATA_W-1:0] humi_reading,
  output logic                     alarm
);

  logic temp_hit;
  logic humi_hit;

  // limit checks, only for channels seen at least once
  assign temp_hit = status.temp_ever_seen &&
                    ((limits.enable_mask[EN_TEMP_HIGH] && (temp_reading > limits.temp_high)) ||
                     (limits.enable_mask[EN_TEMP_LOW]  && (temp_reading < limits.temp_low)));
  assign humi_hit = status.humi_ever_seen &&
                    ((limits.enable_mask[EN_HUMI_HIGH] && (humi_reading > limits.humi_high)) ||
                     (limits.enable_mask[EN_HUMI_LOW]  && (humi_reading < limits.humi_low)));

  // monitor off wins, then missing data, then limits
  always_comb begin
    if (!limits.enable_mask[EN_MONITOR]) begin
      alarm = 1'b0;
    end else if (!status.temp_present || !status.humi_present) begin
      alarm = limits.enable_mask[EN_MISSING];
    end else begin
      alarm = temp_hit || humi_hit;
    end
  end

endmodule
